[sv/dsrs_pkg.sv]
// ----------------------------------------------------------------------------
// Delta skip run scanner package
// Shared widths, limits and the input stage record of the scanner.
// ----------------------------------------------------------------------------
package dsrs_pkg;

    localparam int BYTE_W = 8;
    localparam int OUT_W  = 13;
    localparam int RUN_W  = 9;
    localparam int MATCH_W = 8;

    localparam logic [RUN_W-1:0]   RUN_MAX       = 9'd511;
    localparam logic [MATCH_W-1:0] MATCH_RESET   = 8'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] new_byte;
        logic [BYTE_W-1:0] old_byte;
        logic              last;
    } pair_t;

endpackage

[sv/delta_skip_run_scanner_unit.sv]
// ----------------------------------------------------------------------------
// Delta skip run scanner
// Scans a span of new and old pixel byte pairs and reports the length of the
// leading changed stretch when the final pair of the span has been seen.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  pair      pair_valid/stall     new_byte, old_byte, last
//  result    result_valid/stall   changed_length
//  cfg       cfg_valid/ready      must_match
//
// Each pair waits in the input register while the scan logic updates the
// state, so a pair can be accepted in every cycle unless a stalled result
// holds back a closing pair, whose result is registered as it is processed.
// Reset clears the scan state, empties both registers and sets must_match to 3.
// A stalled result only holds back a pair that closes a span; other pairs
// keep flowing while the result waits.
module delta_skip_run_scanner_unit #(
    parameter int MAX_SPAN = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pair_valid,
    output logic                        pair_stall,
    input  logic [dsrs_pkg::BYTE_W-1:0] new_byte,
    input  logic [dsrs_pkg::BYTE_W-1:0] old_byte,
    input  logic                        last,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [dsrs_pkg::OUT_W-1:0]  changed_length,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dsrs_pkg::MATCH_W-1:0] must_match
);
    import dsrs_pkg::*;

    localparam int PW = $clog2(MAX_SPAN + 1);
    localparam int AW = (PW > OUT_W) ? PW : OUT_W;
    localparam int CW = (PW > MATCH_W) ? PW : MATCH_W;
    localparam logic [PW-1:0] SPAN_LIMIT = PW'(MAX_SPAN);

    logic [MATCH_W-1:0] must_match_reg;
    pair_t              pair_reg;
    logic               pair_valid_reg;
    logic               result_valid_reg;
    logic [OUT_W-1:0]   changed_length_reg;
    logic [OUT_W-1:0]   changed_length_next;

    logic [PW-1:0]    position_reg, position_next;
    logic [PW-1:0]    run_start_reg, run_start_next;
    logic [RUN_W-1:0] run_length_reg, run_length_next;
    logic             in_run_reg, in_run_next;
    logic [PW-1:0]    prev_start_reg, prev_start_next;
    logic             prev_valid_reg, prev_valid_next;
    logic             found_reg, found_next;
    logic [PW-1:0]    found_pos_reg, found_pos_next;

    logic          slot_free;
    logic          process;
    logic          is_equal;
    logic [PW-1:0] answer;
    logic [PW-1:0] gap;
    logic          near_end;
    logic [AW-1:0] answer_ext;

    assign cfg_ready      = 1'b1;
    assign slot_free      = !result_valid_reg || !result_stall;
    assign process        = pair_valid_reg && (!pair_reg.last || slot_free);
    assign pair_stall     = pair_valid_reg && !process;
    assign result_valid   = result_valid_reg;
    assign changed_length = changed_length_reg;
    assign is_equal       = (pair_reg.new_byte == pair_reg.old_byte);

    always_comb
    begin
        position_next   = position_reg;
        run_start_next  = run_start_reg;
        run_length_next = run_length_reg;
        in_run_next     = in_run_reg;
        prev_start_next = prev_start_reg;
        prev_valid_next = prev_valid_reg;
        found_next      = found_reg;
        found_pos_next  = found_pos_reg;

        if (position_reg < SPAN_LIMIT)
        begin
            if (is_equal)
            begin
                if (!in_run_reg)
                begin
                    in_run_next     = 1'b1;
                    run_start_next  = position_reg;
                    run_length_next = '0;
                end
                if (run_length_next < RUN_MAX)
                begin
                    run_length_next = run_length_next + 1'b1;
                end
                if (!found_reg && (run_length_next >= RUN_W'(must_match_reg)))
                begin
                    found_next     = 1'b1;
                    found_pos_next = run_start_next;
                end
            end
            else if (in_run_reg)
            begin
                prev_start_next = run_start_reg;
                prev_valid_next = 1'b1;
                in_run_next     = 1'b0;
            end
            position_next = position_reg + 1'b1;
        end

        gap      = position_next - prev_start_next;
        near_end = prev_valid_next && (CW'(gap) < CW'(must_match_reg));

        if (found_next)
        begin
            answer = found_pos_next;
        end
        else if (in_run_next && !near_end)
        begin
            answer = run_start_next;
        end
        else
        begin
            answer = position_next;
        end
        answer_ext          = AW'(answer);
        changed_length_next = answer_ext[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            must_match_reg   <= MATCH_RESET;
            pair_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            position_reg     <= '0;
            run_start_reg    <= '0;
            run_length_reg   <= '0;
            in_run_reg       <= 1'b0;
            prev_start_reg   <= '0;
            prev_valid_reg   <= 1'b0;
            found_reg        <= 1'b0;
            found_pos_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                must_match_reg <= must_match;
            end

            if (!pair_stall)
            begin
                pair_valid_reg <= pair_valid;
            end

            if (process && pair_reg.last)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            if (process)
            begin
                if (pair_reg.last)
                begin
                    position_reg   <= '0;
                    run_start_reg  <= '0;
                    run_length_reg <= '0;
                    in_run_reg     <= 1'b0;
                    prev_start_reg <= '0;
                    prev_valid_reg <= 1'b0;
                    found_reg      <= 1'b0;
                    found_pos_reg  <= '0;
                end
                else
                begin
                    position_reg   <= position_next;
                    run_start_reg  <= run_start_next;
                    run_length_reg <= run_length_next;
                    in_run_reg     <= in_run_next;
                    prev_start_reg <= prev_start_next;
                    prev_valid_reg <= prev_valid_next;
                    found_reg      <= found_next;
                    found_pos_reg  <= found_pos_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair_valid && !pair_stall)
        begin
            pair_reg.new_byte <= new_byte;
            pair_reg.old_byte <= old_byte;
            pair_reg.last     <= last;
        end
        if (process && pair_reg.last)
        begin
            changed_length_reg <= changed_length_next;
        end
    end

endmodule

[sv/dsrs_checker.sv]
// ----------------------------------------------------------------------------
// Delta skip run scanner checker
// Port-level assertions on the scanner, attached to the top level by bind.
// ----------------------------------------------------------------------------
module dsrs_checker #(
    parameter int MAX_SPAN = 4096
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       pair_stall,
    input logic                       result_valid,
    input logic                       result_stall,
    input logic [dsrs_pkg::OUT_W-1:0] changed_length,
    input logic                       cfg_ready
);
    import dsrs_pkg::*;

    localparam int OUT_MAX = (1 << OUT_W) - 1;

    // A held result keeps its value until it is transferred.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(changed_length))
    else $error("held result changed");

    // The input side only stalls behind a result that cannot be delivered.
    assert property (@(posedge clk) disable iff (!rst_n)
        pair_stall |-> result_valid && result_stall)
    else $error("input stalled while result path is free");

    // A changed length never exceeds the longest span.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (MAX_SPAN > OUT_MAX) || (int'(changed_length) <= MAX_SPAN))
    else $error("changed length beyond span limit");

    // Reset leaves no result pending.
    assert property (@(posedge clk) !rst_n |-> !result_valid)
    else $error("result valid during reset");

    // The configuration register accepts writes at any time after reset.
    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind delta_skip_run_scanner_unit dsrs_checker #(
    .MAX_SPAN(MAX_SPAN)
) u_dsrs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .pair_stall     (pair_stall),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .changed_length (changed_length),
    .cfg_ready      (cfg_ready)
);
